[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// The same on the block's own clock and reset names.
`define ASSERT_RST(label, prop) `ASSERT_CLK(label, clock, reset, prop)

`endif

[sv/kcl_pkg.sv]
package kcl_pkg;

   localparam int CODE_DIGITS_DEF = 4;

   localparam int SYM_W = 8;
   localparam int KEY_W = 4;
   localparam int HOLD_W = 8;

   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [HOLD_W-1:0] hold_type;

   typedef enum logic [1:0] {
      PH_SET    = 2'd0,
      PH_LOCKED = 2'd1,
      PH_BAD    = 2'd2,
      PH_OPEN   = 2'd3
   } kcl_phase_type;

   localparam logic FUNC_TICK = 1'b1;

   localparam key_type KEY_OK = 4'd11;
   localparam key_type KEY_CANCEL = 4'd12;

   localparam sym_type SYM_DASH = 8'd45;
   localparam sym_type SYM_LOCKED = 8'd13;

   localparam hold_type HOLD_TICKS_RST = 8'd200;
   localparam hold_type HOLD_MAX = 8'd255;

   localparam sym_type MSG_OPEN [0:3] = '{8'd0, 8'd14, 8'd15, 8'd16};
   localparam sym_type MSG_BAD [0:3] = '{8'd8, 8'd17, 8'd0, 8'd18};

   typedef struct packed {
      logic    func;
      key_type key;
   } kcl_req_type;

   typedef struct packed {
      sym_type    symbol_first;
      sym_type    symbol_second;
      sym_type    symbol_third;
      sym_type    symbol_fourth;
      logic [1:0] phase;
   } kcl_rsp_type;

   // Control state handed between the state registers and the update logic.
   typedef struct packed {
      kcl_phase_type phase;
      hold_type      hold_count;
   } kcl_ctrl_type;

endpackage

[sv/kcl_update.sv]
module kcl_update
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF,
   parameter int SHOWN_LEN = (CODE_DIGITS > 4) ? CODE_DIGITS : 4,
   parameter int POS_W = $clog2(CODE_DIGITS + 2)
) (
   input  kcl_req_type  item,
   input  hold_type     hold_ticks,
   input  kcl_ctrl_type ctrl_cur,
   input  [POS_W-1:0]   pos_cur,
   input  sym_type      shown_cur [SHOWN_LEN],
   input  sym_type      code_cur [CODE_DIGITS],
   output kcl_ctrl_type ctrl_next,
   output [POS_W-1:0]   pos_next,
   output sym_type      shown_next [SHOWN_LEN],
   output sym_type      code_next [CODE_DIGITS]
);

   logic [POS_W-1:0] pos_c;
   kcl_ctrl_type     ctrl_c;
   sym_type          shown_c [SHOWN_LEN];
   sym_type          code_c [CODE_DIGITS];

   assign pos_next = pos_c;
   assign ctrl_next = ctrl_c;
   assign shown_next = shown_c;
   assign code_next = code_c;

   always_comb begin
      logic     full;
      logic     match;
      hold_type hold_inc;

      ctrl_c = ctrl_cur;
      pos_c = pos_cur;
      shown_c = shown_cur;
      code_c = code_cur;

      full = (pos_cur == POS_W'(CODE_DIGITS + 1));
      match = 1'b1;
      for (int k = 0; k < CODE_DIGITS; k++) begin
         if (code_cur[k] != shown_cur[k]) begin
            match = 1'b0;
         end
      end
      hold_inc = (ctrl_cur.hold_count != HOLD_MAX) ? ctrl_cur.hold_count + 8'd1
                                                   : ctrl_cur.hold_count;

      if (item.func == FUNC_TICK) begin
         if (ctrl_cur.phase == PH_BAD) begin
            ctrl_c.hold_count = hold_inc;
            if (hold_inc >= hold_ticks) begin
               ctrl_c.hold_count = '0;
               ctrl_c.phase = PH_LOCKED;
               pos_c = POS_W'(1);
               for (int k = 0; k < SHOWN_LEN; k++) begin
                  shown_c[k] = SYM_LOCKED;
               end
            end
         end
      end else if (ctrl_cur.phase == PH_SET || ctrl_cur.phase == PH_LOCKED) begin
         if (item.key == KEY_CANCEL) begin
            pos_c = POS_W'(1);
            for (int k = 0; k < SHOWN_LEN; k++) begin
               shown_c[k] = (ctrl_cur.phase == PH_SET) ? SYM_DASH : SYM_LOCKED;
            end
         end else if (full && item.key == KEY_OK) begin
            if (ctrl_cur.phase == PH_SET) begin
               // The entry becomes the code and the display shows the lock marks.
               for (int k = 0; k < CODE_DIGITS; k++) begin
                  code_c[k] = shown_cur[k];
               end
               pos_c = POS_W'(1);
               ctrl_c.phase = PH_LOCKED;
               for (int k = 0; k < SHOWN_LEN; k++) begin
                  shown_c[k] = SYM_LOCKED;
               end
            end else if (match) begin
               ctrl_c.phase = PH_OPEN;
               for (int k = 0; k < 4; k++) begin
                  shown_c[k] = MSG_OPEN[k];
               end
            end else begin
               ctrl_c.phase = PH_BAD;
               ctrl_c.hold_count = '0;
               for (int k = 0; k < 4; k++) begin
                  shown_c[k] = MSG_BAD[k];
               end
            end
         end else if (full) begin
            // A further key on a full entry throws the entry away.
            pos_c = POS_W'(1);
            for (int k = 0; k < SHOWN_LEN; k++) begin
               shown_c[k] = SYM_DASH;
            end
         end else begin
            for (int k = 0; k < CODE_DIGITS; k++) begin
               if (pos_cur == POS_W'(k + 1)) begin
                  shown_c[k] = sym_type'(item.key);
               end
            end
            pos_c = pos_cur + POS_W'(1);
         end
      end
   end

endmodule

[sv/keypad_code_lock_controller_core.sv]
// Keypad code lock. Each item is a key press or a timer tick, and each
// produces one result item carrying the four display symbols and the phase.
// An item enters an input register, the lock state is updated by the single
// combinational step after it, and the result lands in an output register:
// one item per clock cycle while rsp_stall is low. An accepted item passes
// the input and then the output register before its result is offered. The
// state update, including the comparison of the entry with the stored code,
// is the only loop. The user writes the hold time of the BAD message through
// the csr_ port only while the block is idle; the block does not enforce it.
module keypad_code_lock_controller_core
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  kcl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output kcl_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  hold_type    csr_data
);

   localparam int SHOWN_LEN = (CODE_DIGITS > 4) ? CODE_DIGITS : 4;
   localparam int POS_W = $clog2(CODE_DIGITS + 2);

   logic         in_valid_ff, in_valid_in;
   kcl_req_type  in_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   kcl_rsp_type  rsp_data_ff, rsp_data_in;
   hold_type     hold_ticks_ff;

   kcl_ctrl_type     ctrl_ff, ctrl_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   sym_type          shown_ff [SHOWN_LEN];
   sym_type          shown_in [SHOWN_LEN];
   sym_type          code_ff [CODE_DIGITS];
   sym_type          code_in [CODE_DIGITS];

   logic advance;
   logic take;

   // The input item moves on when the result register is empty or emptying.
   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

   kcl_update #(
      .CODE_DIGITS(CODE_DIGITS),
      .SHOWN_LEN  (SHOWN_LEN),
      .POS_W      (POS_W)
   ) u_update (
      .item      (in_data_ff),
      .hold_ticks(hold_ticks_ff),
      .ctrl_cur  (ctrl_ff),
      .pos_cur   (pos_ff),
      .shown_cur (shown_ff),
      .code_cur  (code_ff),
      .ctrl_next (ctrl_in),
      .pos_next  (pos_in),
      .shown_next(shown_in),
      .code_next (code_in)
   );

   always_comb begin
      rsp_data_in.symbol_first = shown_in[0];
      rsp_data_in.symbol_second = shown_in[1];
      rsp_data_in.symbol_third = shown_in[2];
      rsp_data_in.symbol_fourth = shown_in[3];
      rsp_data_in.phase = ctrl_in.phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ticks_ff <= HOLD_TICKS_RST;
         ctrl_ff.phase <= PH_SET;
         ctrl_ff.hold_count <= '0;
         pos_ff <= POS_W'(1);
         for (int k = 0; k < SHOWN_LEN; k++) begin
            shown_ff[k] <= SYM_DASH;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            hold_ticks_ff <= csr_data;
         end
         if (advance) begin
            ctrl_ff <= ctrl_in;
            pos_ff <= pos_in;
            shown_ff <= shown_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         code_ff <= code_in;
      end
   end

endmodule

[sv/kcl_checker.sv]
`include "assert_macros.svh"

module kcl_checker
   import kcl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input kcl_rsp_type rsp_data
);

   // A result waiting on a stall is held unchanged.
   `ASSERT_RST(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // Once open, the lock never leaves the open phase.
   `ASSERT_RST(a_open_sticky, rsp_valid && rsp_data.phase == PH_OPEN |=> !rsp_valid || rsp_data.phase == PH_OPEN)

   // The open phase always shows the OPEN message.
   `ASSERT_RST(a_open_msg, rsp_valid && rsp_data.phase == PH_OPEN |-> rsp_data.symbol_first == MSG_OPEN[0] && rsp_data.symbol_second == MSG_OPEN[1] && rsp_data.symbol_third == MSG_OPEN[2] && rsp_data.symbol_fourth == MSG_OPEN[3])

   // The bad phase always shows the BAD message.
   `ASSERT_RST(a_bad_msg, rsp_valid && rsp_data.phase == PH_BAD |-> rsp_data.symbol_first == MSG_BAD[0] && rsp_data.symbol_second == MSG_BAD[1] && rsp_data.symbol_third == MSG_BAD[2] && rsp_data.symbol_fourth == MSG_BAD[3])

endmodule

bind keypad_code_lock_controller_core kcl_checker u_kcl_checker (.*);
